>>> hw/rtl/jdcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job dispatcher package
// Shared sizes, codes and types for the per-core job queue dispatcher.
// ----------------------------------------------------------------------------
package jdcq_pkg;

  // Build sizes
  localparam int MAX_CORES   = 8;
  localparam int QUEUE_DEPTH = 64;

  // Field widths
  localparam int OP_W     = 2;
  localparam int CORE_W   = 3;
  localparam int JOB_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Configuration widths
  localparam int MODE_W     = 2;
  localparam int ACT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Derived storage sizes
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W      = CORE_W + PTR_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVE = 2'd0,
    OP_TAKE   = 2'd1,
    OP_PUT    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_RR   = 2'd0,
    MODE_LL   = 2'd1,
    MODE_ZERO = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef logic [MAX_CORES-1:0][CNT_W-1:0] cnt_vec_t;
  typedef logic [MAX_CORES-1:0][PTR_W-1:0] ptr_vec_t;

  // Core choice for an arriving job
  typedef struct packed {
    logic [CORE_W-1:0] core;
    logic [CORE_W-1:0] rr_next;
  } pick_t;

  // Result transaction
  typedef struct packed {
    logic [CORE_W-1:0] core;
    logic [JOB_W-1:0]  job;
    status_e           status;
    logic [LEN_W-1:0]  len;
  } rsp_t;

  // Advance a ring pointer, wrapping at the queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

>>> hw/rtl/jdcq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher request channel
// Valid/ready channel carrying one operation on the core queues.
// ----------------------------------------------------------------------------
interface jdcq_req_if;
  import jdcq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CORE_W-1:0] core;
  logic [JOB_W-1:0]  job_id;

  modport source (output valid, output op, output core, output job_id, input ready);
  modport sink   (input valid, input op, input core, input job_id, output ready);
endinterface

>>> hw/rtl/jdcq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatcher response channel
// Valid/ready channel carrying one result of a queue operation.
// ----------------------------------------------------------------------------
interface jdcq_rsp_if;
  import jdcq_pkg::*;

  logic                valid;
  logic                ready;
  logic [CORE_W-1:0]   chosen_core;
  logic [JOB_W-1:0]    job_out;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    queue_length;

  modport source (output valid, output chosen_core, output job_out, output status,
                  output queue_length, input ready);
  modport sink   (input valid, input chosen_core, input job_out, input status,
                  input queue_length, output ready);
endinterface

>>> hw/rtl/jdcq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job id store
// Single-port-write, single-port-read RAM holding every core's ring buffer,
// addressed by {core, slot}. Read data is registered.
// ----------------------------------------------------------------------------
module jdcq_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [jdcq_pkg::ADDR_W-1:0] waddr_i,
  input  logic [jdcq_pkg::JOB_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [jdcq_pkg::ADDR_W-1:0] raddr_i,
  output logic [jdcq_pkg::JOB_W-1:0]  rdata_o
);
  import jdcq_pkg::*;

  logic [JOB_W-1:0] mem [STORE_DEPTH];
  logic [JOB_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/jdcq_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core picker
// Chooses the target core for an arriving job: round robin, shortest queue
// (lowest index on ties) or core zero, and the next round robin pointer.
// ----------------------------------------------------------------------------
module jdcq_pick (
  input  logic [jdcq_pkg::MODE_W-1:0] mode_i,
  input  logic [jdcq_pkg::ACT_W-1:0]  live_i,
  input  logic [jdcq_pkg::CORE_W-1:0] rr_i,
  input  jdcq_pkg::cnt_vec_t          cnt_i,
  output jdcq_pkg::pick_t             pick_o
);
  import jdcq_pkg::*;

  logic [CORE_W-1:0] rr_core;
  logic [ACT_W-1:0]  rr_inc;
  logic [CORE_W-1:0] best;

  // Round robin: restart at core zero when the pointer lies past the active set
  always_comb begin
    rr_core = (ACT_W'(rr_i) < live_i) ? rr_i : '0;
    rr_inc  = ACT_W'(rr_core) + ACT_W'(1);
  end

  // Shortest queue among the active cores, keep the lowest index on ties
  always_comb begin
    best = '0;
    for (int i = 1; i < MAX_CORES; i++) begin
      if ((ACT_W'(i) < live_i) && (cnt_i[i] < cnt_i[best])) begin
        best = CORE_W'(i);
      end
    end
  end

  // Select by mode
  always_comb begin
    pick_o.rr_next = (rr_inc >= live_i) ? '0 : rr_inc[CORE_W-1:0];
    case (mode_i)
      MODE_RR: pick_o.core = rr_core;
      MODE_LL: pick_o.core = best;
      default: pick_o.core = '0;
    endcase
  end

endmodule

>>> hw/rtl/job_dispatch_core_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job dispatcher with per-core queues
// Keeps one FIFO of job ids per core in a shared RAM; arrivals are placed by
// round robin, shortest queue or core zero, and cores take or put back jobs.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid / ready    | op, core, job_id
//   rsp     | out | valid / ready    | chosen_core, job_out, status, queue_length
//   cfg     | in  | cfg_we_i         | cfg_idx_i, cfg_wdata_i
//
// An operation is accepted in the idle state, then updates counts and writes the RAM;
// a take from a non-empty queue adds a read state for the registered RAM data.
// The next request is accepted once the previous operation has finished; the
// result register lets a new request in while a result still waits.
// A stalled result holds the block in its update step. Reset clears counts and
// pointers and loads round robin with four active cores at once; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module job_dispatch_core_queues (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jdcq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jdcq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  jdcq_req_if.sink                        req,
  jdcq_rsp_if.source                      rsp
);
  import jdcq_pkg::*;

  state_e            state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [ACT_W-1:0]  active_q;
  logic [ACT_W-1:0]  live;

  op_e               op_q;
  logic [CORE_W-1:0] core_q;
  logic [JOB_W-1:0]  job_q;

  logic [CORE_W-1:0] rr_q, rr_d;
  cnt_vec_t          cnt_q, cnt_d;
  ptr_vec_t          head_q, head_d;
  ptr_vec_t          tail_q, tail_d;

  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  pick_t             pick;
  logic              slot_free;
  logic              in_range;
  logic [CORE_W-1:0] tgt;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [JOB_W-1:0]  mem_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RR;
      active_q <= ACT_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_wdata_i[MODE_W-1:0];
        CFG_ACTIVE: active_q <= cfg_wdata_i[ACT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp the active core count to one .. MAX_CORES
  always_comb begin
    if (active_q == '0) begin
      live = ACT_W'(1);
    end else if (active_q > ACT_W'(MAX_CORES)) begin
      live = ACT_W'(MAX_CORES);
    end else begin
      live = active_q;
    end
  end

  // Capture the request transaction
  assign req.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      op_q   <= op_e'(req.op);
      core_q <= req.core;
      job_q  <= req.job_id;
    end
  end

  jdcq_pick u_pick (
    .mode_i (mode_q),
    .live_i (live),
    .rr_i   (rr_q),
    .cnt_i  (cnt_q),
    .pick_o (pick)
  );

  assign slot_free = !rsp_valid_q || rsp.ready;
  assign tgt       = (op_q == OP_ARRIVE) ? pick.core : core_q;
  assign in_range  = (op_q == OP_ARRIVE) || (ACT_W'(core_q) < live);
  assign mem_waddr = {tgt, tail_q[tgt]};
  assign mem_raddr = {tgt, head_q[tgt]};

  // Sequencer: update queue bookkeeping, drive the RAM and load the result
  always_comb begin
    state_d     = state_q;
    rr_d        = rr_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          state_d    = S_IDLE;
          rsp_d.core = tgt;
          rsp_d.job  = '0;
          rsp_d.len  = '0;
          // in round robin mode the pointer advances on every arrival, full queue included
          if ((op_q == OP_ARRIVE) && (mode_q == MODE_RR)) begin
            rr_d = pick.rr_next;
          end
          case (op_q)
            OP_ARRIVE, OP_PUT: begin
              rsp_valid_d = 1'b1;
              if (!in_range) begin
                rsp_d.status = STAT_RANGE;
              end else if (cnt_q[tgt] == CNT_W'(QUEUE_DEPTH)) begin
                rsp_d.status = STAT_FULL;
                rsp_d.len    = LEN_W'(cnt_q[tgt]);
              end else begin
                mem_we       = 1'b1;
                tail_d[tgt]  = ptr_inc(tail_q[tgt]);
                cnt_d[tgt]   = cnt_q[tgt] + CNT_W'(1);
                rsp_d.status = STAT_OK;
                rsp_d.job    = job_q;
                rsp_d.len    = LEN_W'(cnt_q[tgt] + CNT_W'(1));
              end
            end
            OP_TAKE: begin
              if (!in_range) begin
                rsp_d.status = STAT_RANGE;
                rsp_valid_d  = 1'b1;
              end else if (cnt_q[tgt] == '0) begin
                rsp_d.status = STAT_EMPTY;
                rsp_valid_d  = 1'b1;
              end else begin
                // job id arrives from the RAM next cycle
                mem_re       = 1'b1;
                head_d[tgt]  = ptr_inc(head_q[tgt]);
                cnt_d[tgt]   = cnt_q[tgt] - CNT_W'(1);
                rsp_d.status = STAT_OK;
                rsp_d.len    = LEN_W'(cnt_q[tgt] - CNT_W'(1));
                state_d      = S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        rsp_d.job   = mem_rdata;
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Queue bookkeeping and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q        <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rr_q        <= rr_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  jdcq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (job_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Drive the response transaction
  assign rsp.valid        = rsp_valid_q;
  assign rsp.chosen_core  = rsp_q.core;
  assign rsp.job_out      = rsp_q.job;
  assign rsp.status       = rsp_q.status;
  assign rsp.queue_length = rsp_q.len;

endmodule

>>> tb/job_dispatch_core_queues_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job dispatcher testbench
// Drives arrive, take, put-back and no-op transactions into the per-core
// queue dispatcher under several mode and core-count settings, predicts each
// result from an internal copy of the queues and checks every response field
// in order. Both channels idle at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module job_dispatch_core_queues_tb;
  import jdcq_pkg::*;

  // Mode code three is not in the package enum; it behaves as core zero
  localparam logic [MODE_W-1:0] MODE_ZERO_ALIAS = 2'd3;
  localparam int unsigned       IDLE_PCT        = 23;
  localparam int unsigned       SETTLE_CYCLES   = 8;
  localparam int unsigned       CYCLE_LIMIT     = 400000;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  jdcq_req_if req_bus ();
  jdcq_rsp_if rsp_bus ();

  job_dispatch_core_queues dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  // Predicted dispatcher state
  logic [MODE_W-1:0] cfg_mode;
  logic [ACT_W-1:0]  cfg_active;
  logic [CORE_W-1:0] rr_next;
  logic [CNT_W-1:0]  q_count [MAX_CORES];
  logic [PTR_W-1:0]  q_head  [MAX_CORES];
  logic [PTR_W-1:0]  q_tail  [MAX_CORES];
  logic [JOB_W-1:0]  q_ram   [MAX_CORES][QUEUE_DEPTH];

  rsp_t        pending_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          no_idle;

  // Clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall the response channel at random
  always @(negedge clk_i) begin
    rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, core", 0, rsp_bus.chosen_core);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.chosen_core !== want.core)
          report_mismatch("chosen_core", want.core, rsp_bus.chosen_core);
        if (rsp_bus.job_out !== want.job)
          report_mismatch("job_out", want.job, rsp_bus.job_out);
        if (rsp_bus.status !== want.status)
          report_mismatch("status", want.status, rsp_bus.status);
        if (rsp_bus.queue_length !== want.len)
          report_mismatch("queue_length", want.len, rsp_bus.queue_length);
      end
    end
  end

  // Clamp the active core count as the block does
  function automatic int unsigned live_count();
    if (cfg_active == 0) return 1;
    if (cfg_active > MAX_CORES) return MAX_CORES;
    return cfg_active;
  endfunction

  // Append a job to one queue and return the result it produces
  function automatic rsp_t store_job(input int unsigned c, input logic [JOB_W-1:0] job);
    rsp_t r;
    r = '0;
    r.core = CORE_W'(c);
    if (q_count[c] >= QUEUE_DEPTH) begin
      r.status = STAT_FULL;
    end else begin
      q_ram[c][q_tail[c]] = job;
      q_tail[c] = (q_tail[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail[c] + 1'b1;
      q_count[c] = q_count[c] + 1'b1;
      r.status = STAT_OK;
      r.job = job;
    end
    r.len = LEN_W'(q_count[c]);
    return r;
  endfunction

  // Work out the result of one accepted transaction and queue it; a no-op gives no result
  function automatic void predict_dispatch(input op_e op, input logic [CORE_W-1:0] core,
                                           input logic [JOB_W-1:0] job);
    rsp_t        r;
    int unsigned live;
    int unsigned c;
    live = live_count();
    r = '0;
    if (op == OP_NOP) return;
    if (op == OP_ARRIVE) begin
      c = 0;
      if (cfg_mode == MODE_RR) begin
        c = (rr_next < live) ? rr_next : 0;
        rr_next = (c + 1 >= live) ? '0 : CORE_W'(c + 1);
      end else if (cfg_mode == MODE_LL) begin
        for (int i = 1; i < live; i++)
          if (q_count[i] < q_count[c]) c = i;
      end
      r = store_job(c, job);
    end else if (core >= live) begin
      r.core = core;
      r.status = STAT_RANGE;
    end else if (op == OP_TAKE) begin
      r.core = core;
      if (q_count[core] == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.job = q_ram[core][q_head[core]];
        q_head[core] = (q_head[core] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_head[core] + 1'b1;
        q_count[core] = q_count[core] - 1'b1;
        r.status = STAT_OK;
        r.len = LEN_W'(q_count[core]);
      end
    end else begin
      r = store_job(core, job);
    end
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Offer one transaction from a falling edge; return at the accepting edge
  task automatic send_job_op(input op_e op, input logic [CORE_W-1:0] core,
                             input logic [JOB_W-1:0] job);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid  <= 1'b1;
    req_bus.op     <= op;
    req_bus.core   <= core;
    req_bus.job_id <= job;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_dispatch(op, core, job);
  endtask

  // Drop valid, wait for every outstanding result, then let the block finish
  task automatic settle_block();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle_block();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_MODE) cfg_mode = data[MODE_W-1:0];
    else cfg_active = data[ACT_W-1:0];
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [ACT_W-1:0] act);
    write_cfg(CFG_MODE, CFG_DATA_W'(mode));
    write_cfg(CFG_ACTIVE, CFG_DATA_W'(act));
  endtask

  // Mostly in-range cores, with some out of range for the current count
  function automatic logic [CORE_W-1:0] pick_core();
    if ($urandom_range(9) < 8) return CORE_W'($urandom_range(live_count() - 1));
    return CORE_W'($urandom_range(MAX_CORES - 1));
  endfunction

  task automatic random_item(input int unsigned arrive_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < arrive_pct)
      send_job_op(OP_ARRIVE, CORE_W'($urandom_range(7)), JOB_W'($urandom_range(65535)));
    else if (roll < arrive_pct + 30)
      send_job_op(OP_TAKE, pick_core(), JOB_W'($urandom_range(65535)));
    else if (roll < 92)
      send_job_op(OP_PUT, pick_core(), JOB_W'($urandom_range(65535)));
    else
      send_job_op(OP_NOP, CORE_W'($urandom_range(7)), JOB_W'($urandom_range(65535)));
  endtask

  // Extremes of the fields and empty, out-of-range and wrap cases at reset config
  task automatic test_reset_edges();
    send_job_op(OP_TAKE,   3'd0, 16'h0000);
    send_job_op(OP_TAKE,   3'd7, 16'hFFFF);
    send_job_op(OP_PUT,    3'd4, 16'hFFFF);
    send_job_op(OP_ARRIVE, 3'd7, 16'h0000);
    send_job_op(OP_ARRIVE, 3'd0, 16'hFFFF);
    send_job_op(OP_ARRIVE, 3'd5, 16'h5A5A);
    send_job_op(OP_ARRIVE, 3'd2, 16'hA5A5);
    send_job_op(OP_ARRIVE, 3'd1, 16'h1234);
    send_job_op(OP_NOP,    3'd7, 16'hFFFF);
    send_job_op(OP_TAKE,   3'd0, 16'h0000);
    send_job_op(OP_TAKE,   3'd0, 16'hFFFF);
    send_job_op(OP_TAKE,   3'd0, 16'h0000);
    send_job_op(OP_PUT,    3'd1, 16'h8001);
    send_job_op(OP_TAKE,   3'd1, 16'h0000);
    send_job_op(OP_TAKE,   3'd3, 16'h0000);
    send_job_op(OP_TAKE,   3'd2, 16'h0000);
  endtask

  // Round robin restarts at core zero when the pointer passes a reduced count
  task automatic test_rr_restart();
    set_config(MODE_RR, 4'd8);
    repeat (6) send_job_op(OP_ARRIVE, 3'd0, JOB_W'($urandom_range(65535)));
    write_cfg(CFG_ACTIVE, 4'd3);
    send_job_op(OP_ARRIVE, 3'd6, 16'h00FF);
    send_job_op(OP_ARRIVE, 3'd6, 16'hFF00);
  endtask

  // Zero, oversized counts and the spare mode code
  task automatic test_clamped_config();
    set_config(MODE_ZERO_ALIAS, 4'd0);
    send_job_op(OP_ARRIVE, 3'd3, 16'hC0DE);
    send_job_op(OP_PUT,    3'd1, 16'h0001);
    send_job_op(OP_TAKE,   3'd0, 16'h0000);
    set_config(MODE_LL, 4'd15);
    send_job_op(OP_ARRIVE, 3'd0, 16'h7FFF);
    send_job_op(OP_ARRIVE, 3'd0, 16'h8000);
    send_job_op(OP_TAKE,   3'd7, 16'h0000);
  endtask

  // Fill core zero past its depth, then empty it again
  task automatic test_queue_full();
    set_config(MODE_ZERO, 4'd2);
    repeat (QUEUE_DEPTH + 2) send_job_op(OP_ARRIVE, 3'd1, JOB_W'($urandom_range(65535)));
    send_job_op(OP_PUT, 3'd0, JOB_W'($urandom_range(65535)));
    send_job_op(OP_PUT, 3'd1, JOB_W'($urandom_range(65535)));
    repeat (QUEUE_DEPTH + 1) send_job_op(OP_TAKE, 3'd0, JOB_W'($urandom_range(65535)));
  endtask

  // Random traffic under one setting, optionally halting mid-way for all results
  task automatic test_random_traffic(input logic [MODE_W-1:0] mode, input logic [ACT_W-1:0] act,
                                     input int unsigned arrive_pct, input int unsigned n_items,
                                     input bit quiet, input bit mid_pause);
    set_config(mode, act);
    no_idle = quiet;
    for (int n = 0; n < n_items; n++) begin
      if (mid_pause && n == n_items / 2) settle_block();
      random_item(arrive_pct);
    end
    settle_block();
    no_idle = 1'b0;
  endtask

  initial begin
    // Reset values of predictor and inputs
    cfg_mode   = MODE_RR;
    cfg_active = 4'd4;
    rr_next    = '0;
    for (int i = 0; i < MAX_CORES; i++) begin
      q_count[i] = '0;
      q_head[i]  = '0;
      q_tail[i]  = '0;
    end
    error_count    = 0;
    cycle_count    = 0;
    no_idle        = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MODE;
    cfg_wdata_i    = '0;
    req_bus.valid  = 1'b0;
    req_bus.op     = OP_NOP;
    req_bus.core   = '0;
    req_bus.job_id = '0;
    rsp_bus.ready  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_edges();
    test_rr_restart();
    test_clamped_config();
    test_queue_full();
    test_random_traffic(MODE_RR,         4'd1,  45, 180, 1'b0, 1'b0);
    test_random_traffic(MODE_RR,         4'd8,  50, 200, 1'b0, 1'b1);
    test_random_traffic(MODE_LL,         4'd8,  60, 200, 1'b1, 1'b0);
    test_random_traffic(MODE_LL,         4'd3,  40, 180, 1'b0, 1'b0);
    test_random_traffic(MODE_ZERO,       4'd5,  55, 180, 1'b0, 1'b0);
    test_random_traffic(MODE_ZERO_ALIAS, 4'd15, 45, 160, 1'b0, 1'b0);
    test_random_traffic(MODE_LL,         4'd0,  50, 120, 1'b0, 1'b0);
    test_random_traffic(MODE_RR,         4'd5,  35, 180, 1'b0, 1'b0);

    settle_block();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
